@@ hw/rtl/pwl_pkg.sv @@
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants for the piecewise-linear breakpoint table.
// ----------------------------------------------------------------------------
package pwl_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 16;
    localparam int ENTRY_W     = 2 * VAL_W;
    localparam int DVD_W       = 32;
    localparam int STAT_W      = 3;
    localparam int OUT_CNT_W   = 6;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BOUNDS = 3'd2,
        ST_SINGLE = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_CMP,
        S_LD_WR,
        S_Q_RD,
        S_Q_CMP,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_SUM,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/pwl_ram.sv @@
// ----------------------------------------------------------------------------
// pwl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pwl_div.sv @@
// ----------------------------------------------------------------------------
// pwl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwl_div
    import pwl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dividend,
    input  logic [VAL_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [DVD_W-1:0]   o_quotient
);

    localparam int STEP_W = $clog2(DVD_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DVD_W-1:0]  r_dvd, n_dvd;
    logic [VAL_W-1:0]  r_rem, n_rem;
    logic [VAL_W-1:0]  r_dsr, n_dsr;
    logic [VAL_W:0]    w_rem_sh;
    logic [VAL_W+1:0]  w_diff;

    assign w_rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            // A clear sign bit on the trial difference means the divisor fits.
            n_dvd = {r_dvd[DVD_W-2:0], ~w_diff[VAL_W+1]};
            n_rem = w_diff[VAL_W+1] ? w_rem_sh[VAL_W-1:0] : w_diff[VAL_W-1:0];
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

@@ hw/rtl/piecewise_linear_table_interp_core.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_core
// Sorted breakpoint table with piecewise-linear interpolation queries.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries an action, an x and a y.
// A load inserts (x, y) in x order, a query interpolates y at x, and a
// clear empties the table. Every input transfer yields exactly one result
// transfer on the output channel (o_out_valid / i_out_ready) with the value,
// a status code and the number of stored points.
// The block works on one item at a time and is not ready meanwhile.
// A load moves each stored point with a larger x up one slot, then writes
// the new point; the table RAM has one read port with a registered read, so
// each compared entry passes through a read state and a compare state.
// A query scans entries the same way and, when it interpolates, then does a
// multiply, a divider start, a wait until the 32-step bit-serial divider
// reports done, and an add.
// Clears, full-table loads and anything on an empty table go straight to done.
// Results sit in an output register, so the next item is accepted while a
// result waits; a further result waits until the receiver takes the first.
// Synchronous reset empties the table and drops any pending result.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_core
    import pwl_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic signed [VAL_W-1:0]     i_x_value,
    input  logic signed [VAL_W-1:0]     i_y_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [VAL_W-1:0]     o_result_value,
    output logic [STAT_W-1:0]           o_status,
    output logic [OUT_CNT_W-1:0]        o_entry_count
);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic signed [VAL_W-1:0] r_x, n_x;
    logic signed [VAL_W-1:0] r_y, n_y;
    logic signed [VAL_W-1:0] r_lo_x, n_lo_x;
    logic signed [VAL_W-1:0] r_lo_y, n_lo_y;
    logic signed [VAL_W-1:0] r_up_x, n_up_x;
    logic signed [VAL_W-1:0] r_up_y, n_up_y;
    logic signed [2*VAL_W+1:0] r_prod, n_prod;
    logic signed [VAL_W-1:0] r_res, n_res;
    t_status                 r_stat, n_stat;
    logic                    r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_out_res, n_out_res;
    logic [STAT_W-1:0]       r_out_stat, n_out_stat;
    logic [OUT_CNT_W-1:0]    r_out_cnt, n_out_cnt;

    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic [ENTRY_W-1:0]      w_wdata;
    logic [ADDR_W-1:0]       w_raddr;
    logic [ENTRY_W-1:0]      w_rdata;
    logic signed [VAL_W-1:0] w_rx;
    logic signed [VAL_W-1:0] w_ry;
    logic [CNT_W-1:0]        w_idx_m1;
    logic [CNT_W-1:0]        w_idx_p1;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [DVD_W-1:0]        w_quot;
    logic [DVD_W-1:0]        w_prod_mag;
    logic [VAL_W-1:0]        w_dx;
    logic signed [VAL_W:0]   w_dy;
    logic signed [VAL_W:0]   w_dxq;
    logic signed [VAL_W+1:0] w_q;
    logic signed [VAL_W+2:0] w_sum;
    t_status                 w_miss_stat;

    assign w_rx     = w_rdata[ENTRY_W-1:VAL_W];
    assign w_ry     = w_rdata[VAL_W-1:0];
    assign w_idx_m1 = r_idx - 1'b1;
    assign w_idx_p1 = r_idx + 1'b1;

    // The quotient magnitude never exceeds |dy|, so 17 bits hold it.
    assign w_dy       = {r_up_y[VAL_W-1], r_up_y} - {r_lo_y[VAL_W-1], r_lo_y};
    assign w_dxq      = {r_x[VAL_W-1], r_x} - {r_lo_x[VAL_W-1], r_lo_x};
    assign w_dx       = VAL_W'({r_up_x[VAL_W-1], r_up_x} - {r_lo_x[VAL_W-1], r_lo_x});
    assign w_prod_mag = r_prod[2*VAL_W+1] ? DVD_W'(-r_prod) : DVD_W'(r_prod);
    assign w_q        = r_prod[2*VAL_W+1] ? -$signed({1'b0, w_quot[VAL_W:0]})
                                          : $signed({1'b0, w_quot[VAL_W:0]});
    assign w_sum      = (VAL_W+3)'(r_lo_y) + (VAL_W+3)'(w_q);
    assign w_miss_stat = (r_cnt == CNT_W'(1)) ? ST_SINGLE : ST_BOUNDS;

    pwl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pwl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod_mag),
        .i_divisor  (w_dx),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_x         = r_x;
        n_y         = r_y;
        n_lo_x      = r_lo_x;
        n_lo_y      = r_lo_y;
        n_up_x      = r_up_x;
        n_up_y      = r_up_y;
        n_prod      = r_prod;
        n_res       = r_res;
        n_stat      = r_stat;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        n_out_stat  = r_out_stat;
        n_out_cnt   = r_out_cnt;
        w_we        = 1'b0;
        w_waddr     = r_idx[ADDR_W-1:0];
        w_wdata     = {r_x, r_y};
        w_raddr     = r_idx[ADDR_W-1:0];
        w_div_start = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x    = i_x_value;
                    n_y    = i_y_value;
                    n_res  = '0;
                    n_stat = ST_OK;
                    n_idx  = r_cnt;
                    n_state = S_DONE;
                    case (t_action'(i_action))
                        ACT_LOAD: begin
                            if (r_cnt >= CNT_W'(TABLE_DEPTH)) begin
                                n_stat = ST_FULL;
                            end else if (r_cnt == '0) begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = {i_x_value, i_y_value};
                                n_cnt   = CNT_W'(1);
                            end else begin
                                n_state = S_LD_RD;
                            end
                        end
                        ACT_QUERY: begin
                            if (r_cnt == '0) begin
                                n_stat = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_Q_RD;
                            end
                        end
                        ACT_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LD_RD: begin
                w_raddr = w_idx_m1[ADDR_W-1:0];
                n_state = S_LD_CMP;
            end
            S_LD_CMP: begin
                w_we = 1'b1;
                if (w_rx > r_x) begin
                    // Move the larger entry up one slot and keep searching.
                    w_wdata = w_rdata;
                    n_idx   = w_idx_m1;
                    n_state = (r_idx == CNT_W'(1)) ? S_LD_WR : S_LD_RD;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_LD_WR: begin
                w_we    = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                n_state = S_DONE;
            end
            S_Q_RD: begin
                n_state = S_Q_CMP;
            end
            S_Q_CMP: begin
                n_up_x = w_rx;
                n_up_y = w_ry;
                if (w_rx == r_x) begin
                    n_res   = w_ry;
                    n_state = S_DONE;
                end else if (w_rx > r_x) begin
                    // The first entry above x: below the table, or bracketing.
                    if (r_idx == '0) begin
                        n_stat  = w_miss_stat;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end else begin
                    n_lo_x = w_rx;
                    n_lo_y = w_ry;
                    n_idx  = w_idx_p1;
                    if (w_idx_p1 == r_cnt) begin
                        n_stat  = w_miss_stat;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_Q_RD;
                    end
                end
            end
            S_MUL: begin
                n_prod  = (2*VAL_W+2)'(w_dy * w_dxq);
                n_state = S_DSTART;
            end
            S_DSTART: begin
                w_div_start = 1'b1;
                n_state     = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (w_sum > (VAL_W+3)'(32767)) begin
                    n_res = 16'sh7FFF;
                end else if (w_sum < -(VAL_W+3)'(32768)) begin
                    n_res = 16'sh8000;
                end else begin
                    n_res = w_sum[VAL_W-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_out_stat  = r_stat;
                    n_out_cnt   = OUT_CNT_W'(r_cnt);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_x        <= n_x;
        r_y        <= n_y;
        r_lo_x     <= n_lo_x;
        r_lo_y     <= n_lo_y;
        r_up_x     <= n_up_x;
        r_up_y     <= n_up_y;
        r_prod     <= n_prod;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_out_res  <= n_out_res;
        r_out_stat <= n_out_stat;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_res;
    assign o_status       = r_out_stat;
    assign o_entry_count  = r_out_cnt;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TABLE_DEPTH))
        else $error("point count exceeds table depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_result_value == '0)
        else $error("nonzero result with error status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted an item while the previous one is at work");

    a_div_only_interp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DWAIT)
        else $error("divider finished outside an interpolation");
`endif

endmodule

@@ verif/tb_piecewise_linear_table_interp_core.sv @@
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interp_core
// Drives loads, queries and clears into the breakpoint table and checks every
// result against a behavioral table model kept inside this bench.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_interp_core
    import pwl_pkg::*;
();

    localparam int NUM_RANDOM  = 1030;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] x_value;
        logic [15:0] y_value;
        logic        typed;
        logic [15:0] exp_value;
        logic [2:0]  exp_status;
        logic [5:0]  exp_count;
    } t_row;

    typedef struct packed {
        logic [15:0] value;
        logic [2:0]  status;
        logic [5:0]  count;
    } t_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [1:0]              i_action;
    logic signed [VAL_W-1:0] i_x_value;
    logic signed [VAL_W-1:0] i_y_value;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [VAL_W-1:0] o_result_value;
    logic [STAT_W-1:0]       o_status;
    logic [OUT_CNT_W-1:0]    o_entry_count;

    piecewise_linear_table_interp_core u_dut (.*);

    // Model of the breakpoint table.
    int      bp_x [TABLE_DEPTH];
    int      bp_y [TABLE_DEPTH];
    int      bp_count;
    t_result pending_results[$];
    int      error_count;
    int      cycle_count;
    bit      calm;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic t_result interpolate_step(input logic [1:0] act,
                                                 input int x, input int y);
        t_result r;
        int      pos;
        int      lo;
        longint  q;
        longint  s;
        r = '0;
        r.status = ST_OK;
        if (act == ACT_LOAD) begin
            if (bp_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = bp_count;
                while (pos > 0 && bp_x[pos-1] > x) begin
                    bp_x[pos] = bp_x[pos-1];
                    bp_y[pos] = bp_y[pos-1];
                    pos--;
                end
                bp_x[pos] = x;
                bp_y[pos] = y;
                bp_count++;
            end
        end else if (act == ACT_CLEAR) begin
            bp_count = 0;
        end else if (act == ACT_QUERY) begin
            if (bp_count == 0) begin
                r.status = ST_EMPTY;
            end else if (bp_count == 1) begin
                if (x == bp_x[0]) r.value = bp_y[0][15:0];
                else r.status = ST_SINGLE;
            end else if (x < bp_x[0] || x > bp_x[bp_count-1]) begin
                r.status = ST_BOUNDS;
            end else begin
                lo = -1;
                for (int i = 0; i < bp_count; i++) begin
                    if (lo < 0 && bp_x[i] == x) lo = i;
                end
                if (lo >= 0) begin
                    r.value = bp_y[lo][15:0];
                end else begin
                    lo = 0;
                    while (lo + 1 < bp_count && bp_x[lo+1] <= x) lo++;
                    q = (longint'(bp_y[lo+1] - bp_y[lo]) * longint'(x - bp_x[lo]))
                        / longint'(bp_x[lo+1] - bp_x[lo]);
                    s = bp_y[lo] + q;
                    if (s > 32767) s = 32767;
                    if (s < -32768) s = -32768;
                    r.value = s[15:0];
                end
            end
        end
        r.count = bp_count[5:0];
        return r;
    endfunction

    // Valid drops only for an idle gap, so it is never written twice in one step.
    task automatic send_item(input logic [1:0] act, input logic [15:0] x,
                             input logic [15:0] y, input bit idle_ok);
        if (idle_ok && !calm && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 17) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_x_value  <= x;
        i_y_value  <= y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.insert(pending_results.size(),
                               interpolate_step(act, $signed(x), $signed(y)));
    endtask

    // Output side: random back-pressure and the check against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    t_result w;
                    w = pending_results.pop_front();
                    if (o_result_value !== w.value)
                        report_mismatch("result_value", o_result_value, $signed(w.value));
                    if (o_status !== w.status)
                        report_mismatch("status", o_status, w.status);
                    if (o_entry_count !== w.count)
                        report_mismatch("entry_count", o_entry_count, w.count);
                end
            end
            i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [15:0] pick_x();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3, 4: return 16'($urandom_range(40) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    t_row directed[$];

    initial begin
        t_row row;
        logic [1:0] act;
        int pick;
        error_count = 0;
        cycle_count = 0;
        calm        = 1'b0;
        bp_count    = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = ACT_LOAD;
        i_x_value   = '0;
        i_y_value   = '0;
        i_out_ready = 1'b0;
        // action, x, y, typed, value, status, count
        directed = '{
            '{ACT_QUERY, 16'h0000, 16'h0000, 1'b1, 16'h0000, ST_EMPTY,  6'd0},
            '{ACT_NONE,  16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, ST_OK,     6'd0},
            '{ACT_LOAD,  16'h0100, 16'h0200, 1'b1, 16'h0000, ST_OK,     6'd1},
            '{ACT_QUERY, 16'h0100, 16'h0000, 1'b1, 16'h0200, ST_OK,     6'd1},
            '{ACT_QUERY, 16'h0101, 16'h0000, 1'b1, 16'h0000, ST_SINGLE, 6'd1},
            '{ACT_LOAD,  16'h8000, 16'h7FFF, 1'b0, 16'h0, ST_OK, 6'd0},
            '{ACT_LOAD,  16'h7FFF, 16'h8000, 1'b0, 16'h0, ST_OK, 6'd0},
            '{ACT_LOAD,  16'h0100, 16'h1111, 1'b0, 16'h0, ST_OK, 6'd0},
            '{ACT_QUERY, 16'h0100, 16'h0000, 1'b1, 16'h0200, ST_OK,     6'd4},
            '{ACT_QUERY, 16'h8001, 16'h0000, 1'b0, 16'h0, ST_OK, 6'd0},
            '{ACT_QUERY, 16'h7FFE, 16'h0000, 1'b0, 16'h0, ST_OK, 6'd0},
            '{ACT_QUERY, 16'h0000, 16'h0000, 1'b0, 16'h0, ST_OK, 6'd0},
            '{ACT_CLEAR, 16'h1234, 16'h5678, 1'b1, 16'h0000, ST_OK,     6'd0},
            '{ACT_LOAD,  16'h0000, 16'h8000, 1'b0, 16'h0, ST_OK, 6'd0},
            '{ACT_LOAD,  16'h0002, 16'h7FFF, 1'b0, 16'h0, ST_OK, 6'd0},
            '{ACT_QUERY, 16'h0001, 16'h0000, 1'b0, 16'h0, ST_OK, 6'd0},
            '{ACT_QUERY, 16'h0003, 16'h0000, 1'b1, 16'h0000, ST_BOUNDS, 6'd2},
            '{ACT_QUERY, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, ST_BOUNDS, 6'd2}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) begin
            row = directed[i];
            send_item(row.action, row.x_value, row.y_value, 1'b1);
            if (row.typed) begin
                t_result t;
                t = pending_results[$];
                if (t.value !== row.exp_value || t.status !== row.exp_status
                        || t.count !== row.exp_count)
                    report_mismatch("directed row", i, 0);
                pending_results[$] = '{row.exp_value, row.exp_status, row.exp_count};
            end
        end
        // Fill the table to the top and push past it, extremes mixed in.
        while (bp_count < TABLE_DEPTH)
            send_item(ACT_LOAD, pick_x(), 16'($urandom), 1'b1);
        send_item(ACT_LOAD, 16'h7FFF, 16'h7FFF, 1'b1);
        send_item(ACT_QUERY, 16'h0000, 16'h0000, 1'b1);
        // Hold off until the output side has drained.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm = (n >= 400 && n < 550);
            pick = $urandom_range(99);
            if (pick < 3) act = ACT_CLEAR;
            else if (pick < 5) act = ACT_NONE;
            else if (pick < 40 || bp_count < 2) act = ACT_LOAD;
            else act = ACT_QUERY;
            if (act == ACT_QUERY && bp_count > 0 && $urandom_range(3) == 0)
                send_item(act, 16'(bp_x[$urandom_range(bp_count - 1)]), 16'($urandom),
                          1'b1);
            else
                send_item(act, pick_x(), 16'($urandom), 1'b1);
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
